[rtl/rtp_pcmu_pkg.sv]
// Shared types, constants and header byte selection for the PCMU RTP packetizer.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package rtp_pcmu_pkg;

   localparam int unsigned DEFAULT_SAMPLES_PER_PACKET = 160;
   localparam int unsigned HDR_BYTES                  = 12;
   localparam int unsigned HDR_IDX_W                  = $clog2(HDR_BYTES + 1);
   localparam int unsigned CSR_IDX_W                  = 2;
   localparam int unsigned CSR_DATA_W                 = 32;

   localparam logic [7:0] RTP_FIRST_BYTE  = 8'h80;  // version 2, no P/X/CC
   localparam logic [7:0] RTP_SECOND_BYTE = 8'h00;  // marker clear, payload type 0

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_ID = 2'd0,
      CSR_INIT_SEQ  = 2'd1,
      CSR_INIT_TS   = 2'd2
   } csr_idx_type;

   // One accepted sample together with the header fields of its packet.
   typedef struct packed {
      logic [7:0]  sample;
      logic        close;
      logic        needs_hdr;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
   } item_type;

   function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                           input logic [15:0] seq,
                                           input logic [31:0] ts,
                                           input logic [31:0] ssrc);
      logic [7:0] b;
      case (idx)
         4'd0:    b = RTP_FIRST_BYTE;
         4'd1:    b = RTP_SECOND_BYTE;
         4'd2:    b = seq[15:8];
         4'd3:    b = seq[7:0];
         4'd4:    b = ts[31:24];
         4'd5:    b = ts[23:16];
         4'd6:    b = ts[15:8];
         4'd7:    b = ts[7:0];
         4'd8:    b = ssrc[31:24];
         4'd9:    b = ssrc[23:16];
         4'd10:   b = ssrc[15:8];
         4'd11:   b = ssrc[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/rtp_pcmu_if.sv]
// Valid/ready channel interfaces: sample input, packet byte output, register writes.
// Depends on rtp_pcmu_pkg for the register port widths.
`default_nettype none

interface rtp_pcmu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_byte;
   logic       buffer_end;

   modport source (output valid, sample_byte, buffer_end, input ready);
   modport sink   (input valid, sample_byte, buffer_end, output ready);
endinterface

interface rtp_pcmu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       is_header;
   logic       packet_last;

   modport source (output valid, packet_byte, is_header, packet_last, input ready);
   modport sink   (input valid, packet_byte, is_header, packet_last, output ready);
endinterface

interface rtp_pcmu_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rtp_pcmu_pkg::CSR_IDX_W-1:0]  index;
   logic [rtp_pcmu_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/rtp_pcmu_packetizer_unit.sv]
// Top level of the PCMU RTP packetizer: context block plus byte sequencer.
// Depends on rtp_pcmu_pkg, rtp_pcmu_if, rtp_pcmu_ctx and rtp_pcmu_emit.
//
// Usage:
//   req_bus carries one mu-law sample per beat with a buffer_end flag.
//   rsp_bus carries the packet one byte per beat; is_header marks the
//   12 header bytes, packet_last the final payload byte of a packet.
//   csr_bus writes SSRC (index 0), sequence (1) and timestamp (2); it is
//   always ready, and a sequence or timestamp write loads the running
//   value at once. Write registers only while the block is idle.
// Timing:
//   An accepted sample passes the item slot, then the output register, to
//   rsp_bus. Bytes go out one per cycle while rsp_bus is ready; a packet
//   start adds 12 header bytes and mid-packet samples sustain 1 per cycle.
//   req_bus stays ready while the item slot is free or finishing its last
//   byte, so a new sample enters while the output register still holds one.
// Reset:
//   Synchronous reset clears SSRC, sequence and timestamp to zero, closes
//   any open packet and drops held beats. A stall on rsp_bus holds the
//   output beat and, once the item slot is full, backpressures req_bus.
`default_nettype none

module rtp_pcmu_packetizer_unit #(
   parameter int unsigned SAMPLES_PER_PACKET = rtp_pcmu_pkg::DEFAULT_SAMPLES_PER_PACKET
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rtp_pcmu_req_if.sink     req_bus,
   rtp_pcmu_rsp_if.source   rsp_bus,
   rtp_pcmu_csr_if.sink     csr_bus
);

   rtp_pcmu_pkg::item_type item;
   logic                   req_accept;
   logic                   csr_we;

   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid && csr_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   rtp_pcmu_ctx #(
      .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET)
   ) u_ctx (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .sample_byte (req_bus.sample_byte),
      .buffer_end  (req_bus.buffer_end),
      .csr_we      (csr_we),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .item        (item)
   );

   rtp_pcmu_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .item     (item),
      .rsp_bus  (rsp_bus)
   );

   a_hdr_never_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_header |-> !rsp_bus.packet_last)
      else $error("header beat flagged as packet end");

   a_reset_drops_beat: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_bus.valid)
      else $error("output beat valid right after reset");

   a_stall_blocks_new: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready && $past(req_accept) && !$past(item.needs_hdr)
      |-> !req_bus.ready)
      else $error("slot accepted a sample while output stalled and slot full");

endmodule

`default_nettype wire

[rtl/rtp_pcmu_ctx.sv]
// Packet context: SSRC, sequence, sample clock and fill count; register writes.
// Builds the item record for each accepted sample. Depends on rtp_pcmu_pkg.
`default_nettype none

module rtp_pcmu_ctx #(
   parameter int unsigned SAMPLES_PER_PACKET = rtp_pcmu_pkg::DEFAULT_SAMPLES_PER_PACKET
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [7:0]                          sample_byte,
   input  wire logic                                buffer_end,
   input  wire logic                                csr_we,
   input  wire logic [rtp_pcmu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rtp_pcmu_pkg::CSR_DATA_W-1:0] csr_data,
   output rtp_pcmu_pkg::item_type                   item
);

   localparam int unsigned FILL_W = $clog2(SAMPLES_PER_PACKET + 1);
   localparam logic [FILL_W:0] SPP = (FILL_W + 1)'(SAMPLES_PER_PACKET);

   logic [31:0]       ssrc_ff, ssrc_in;
   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       clk_ff, clk_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W:0]   fill_inc;
   logic              close;

   assign fill_inc = {1'b0, fill_ff} + (FILL_W + 1)'(1);
   assign close    = buffer_end || (fill_inc >= SPP);

   always_comb begin
      item.sample    = sample_byte;
      item.close     = close;
      item.needs_hdr = (fill_ff == '0);
      item.seq       = seq_ff;
      item.ts        = clk_ff;
      item.ssrc      = ssrc_ff;
   end

   always_comb begin
      ssrc_in = ssrc_ff;
      seq_in  = seq_ff;
      clk_in  = clk_ff;
      fill_in = fill_ff;
      if (accept) begin
         clk_in  = clk_ff + 32'd1;
         fill_in = close ? '0 : fill_inc[FILL_W-1:0];
         if (close) begin
            seq_in = seq_ff + 16'd1;
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            rtp_pcmu_pkg::CSR_SOURCE_ID: ssrc_in = csr_data;
            rtp_pcmu_pkg::CSR_INIT_SEQ:  seq_in  = csr_data[15:0];
            rtp_pcmu_pkg::CSR_INIT_TS:   clk_in  = csr_data;
            default: ;  // unknown index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ssrc_ff <= '0;
         seq_ff  <= '0;
         clk_ff  <= '0;
         fill_ff <= '0;
      end else begin
         ssrc_ff <= ssrc_in;
         seq_ff  <= seq_in;
         clk_ff  <= clk_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rtp_pcmu_emit.sv]
// Byte sequencer: holds one item, walks its header bytes when due and then the sample
// into a registered output beat. Depends on rtp_pcmu_pkg and rtp_pcmu_if.
`default_nettype none

module rtp_pcmu_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  rtp_pcmu_pkg::item_type      item,
   rtp_pcmu_rsp_if.source              rsp_bus
);

   localparam int unsigned IDX_W = rtp_pcmu_pkg::HDR_IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(rtp_pcmu_pkg::HDR_BYTES);

   rtp_pcmu_pkg::item_type slot_ff, slot_in;
   logic                   slot_valid_ff, slot_valid_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_hdr_ff, out_hdr_in;
   logic                   out_last_ff, out_last_in;

   logic out_load, last_beat, slot_done, take;

   assign last_beat = (idx_ff == LAST_IDX);
   assign out_load  = slot_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign slot_done = out_load && last_beat;
   assign in_ready  = !slot_valid_ff || slot_done;
   assign take      = in_valid && in_ready;

   always_comb begin
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      idx_in        = idx_ff;
      if (take) begin
         slot_in       = item;
         slot_valid_in = 1'b1;
         idx_in        = item.needs_hdr ? '0 : LAST_IDX;  // skip header mid-packet
      end else if (slot_done) begin
         slot_valid_in = 1'b0;
      end else if (out_load) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_hdr_in   = out_hdr_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = last_beat ? slot_ff.sample
                                  : rtp_pcmu_pkg::hdr_byte(idx_ff, slot_ff.seq,
                                                           slot_ff.ts, slot_ff.ssrc);
         out_hdr_in   = !last_beat;
         out_last_in  = last_beat && slot_ff.close;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      out_byte_ff <= out_byte_in;
      out_hdr_ff  <= out_hdr_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.packet_byte = out_byte_ff;
   assign rsp_bus.is_header   = out_hdr_ff;
   assign rsp_bus.packet_last = out_last_ff;

endmodule

`default_nettype wire
